>>> design/pvmh_pkg.sv
// Shared types and constants for the three-axis magnitude peak hold.
package pvmh_pkg;

  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned SQ_W            = 32;
  localparam int unsigned OUT_W           = 16;
  localparam int unsigned ROOT_STEPS      = SQ_W / 2;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_ACC,
    S_CMP,
    S_ROOT,
    S_DONE
  } state_t;

endpackage

>>> design/peak_vector_magnitude_hold.sv
// Peak hold of squared three-axis magnitude with iterative square root on read.
// Sample word: three multiply and accumulate steps, then a compare, before ready returns.
// Read word: the result follows the 16 restoring root steps through one shared
// subtractor; it waits longer if the output register is still full.
// One word in flight at a time; the result register lets the next word in meanwhile.
// Synchronous active-low reset clears the held peak, the sequencer and the output valid.
module peak_vector_magnitude_hold #(
  parameter int unsigned SAMPLE_BITS = pvmh_pkg::SAMPLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // accel_x, accel_y, accel_z from the lowest bit up, zero padded to whole bytes
  input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0] in_tdata,
  // req_type
  input  logic in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // peak_magnitude
  output logic [pvmh_pkg::OUT_W-1:0] out_tdata
);
  import pvmh_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned PROD_W = 2 * SB;
  localparam int unsigned SUM_W = 2 * SB + 2;

  state_t              state_r, state_nxt;
  logic [3*SB-1:0]     samp_r, samp_nxt;
  logic [1:0]          ax_r, ax_nxt;
  logic [PROD_W-1:0]   prod_r, prod_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SQ_W-1:0]     peak_r, peak_nxt;
  logic [SQ_W-1:0]     rem_r, rem_nxt;
  logic [SQ_W-1:0]     root_r, root_nxt;
  logic [SQ_W-1:0]     bit_r, bit_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [SB-1:0]       axis_raw;
  logic [SB-1:0]       axis_mag;
  logic [63:0]         sum_ext;
  logic [SQ_W-1:0]     sum_sat;
  logic [SQ_W-1:0]     trial;
  logic                in_acc;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // shared unit: magnitude of the selected axis
  assign axis_raw = samp_r[ax_r*SB +: SB];
  assign axis_mag = axis_raw[SB-1] ? SB'(~axis_raw + 1'b1) : axis_raw;

  // clamp the sum of squares to 32 bits
  assign sum_ext = 64'(sum_r);
  assign sum_sat = (|sum_ext[63:SQ_W]) ? '1 : sum_ext[SQ_W-1:0];

  assign trial = root_r + bit_r;

  always_comb begin
    state_nxt     = state_r;
    samp_nxt      = samp_r;
    ax_nxt        = ax_r;
    prod_nxt      = prod_r;
    sum_nxt       = sum_r;
    peak_nxt      = peak_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == REQ_READ) begin
            rem_nxt   = peak_r;
            root_nxt  = '0;
            bit_nxt   = SQ_W'(1) << (SQ_W - 2);
            peak_nxt  = '0;
            state_nxt = S_ROOT;
          end else begin
            samp_nxt  = in_tdata[3*SB-1:0];
            ax_nxt    = 2'd0;
            sum_nxt   = '0;
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        prod_nxt  = PROD_W'(axis_mag) * PROD_W'(axis_mag);
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt = sum_r + SUM_W'(prod_r);
        if (ax_r == 2'd2) begin
          state_nxt = S_CMP;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = S_MUL;
        end
      end
      S_CMP: begin
        // keep the peak on an equal value
        if (sum_sat > peak_r) begin
          peak_nxt = sum_sat;
        end
        state_nxt = S_IDLE;
      end
      S_ROOT: begin
        if (rem_r >= trial) begin
          rem_nxt  = rem_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = root_r[OUT_W-1:0];
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      peak_r      <= peak_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r     <= samp_nxt;
    ax_r       <= ax_nxt;
    prod_r     <= prod_nxt;
    sum_r      <= sum_nxt;
    rem_r      <= rem_nxt;
    root_r     <= root_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == REQ_READ) |=> (peak_r == '0))
    else $error("peak not cleared after read");

  a_peak_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tvalid && in_tready && in_tuser == REQ_READ) |=> (peak_r >= $past(peak_r)))
    else $error("peak fell without a read");

  a_root_bit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> $onehot(bit_r))
    else $error("root step bit not one-hot");

  a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (root_r[SQ_W-1:OUT_W] == '0))
    else $error("root exceeds output width");
`endif

endmodule
